// File: design/sha256_stream_hash_assert.svh
// Assertion macros shared by the SHA-256 stream hasher modules
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: design/sha_pkg.sv
// Package: SHA-256 constants, queue entry type, round functions
package sha_pkg;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_item;
	} item_t;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] r);
		word_t k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

// File: design/sha_stream_if.sv
// Valid/ready channel interface
interface sha_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/sha_queue.sv
// Front part: item queue between acceptance and the compression engine
`include "sha256_stream_hash_assert.svh"
module sha_queue #(
	parameter int Depth = sha_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha_pkg::item_t      in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sha_pkg::item_t      out_item
);
	localparam int AW = $clog2(Depth);
	sha_pkg::item_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != Depth[AW:0]);
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	// drop items with neither flag; they change nothing
	assign push = in_valid && in_ready && (in_item.byte_valid || in_item.last_item);
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`SHA_ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt_q < Depth[AW:0])
	`SHA_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, cnt_q != '0)
	`SHA_ASSERT_NXT(a_cnt_push, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// File: design/sha_engine.sv
// Back part: block buffer, padding and 64-round compression
`include "sha256_stream_hash_assert.svh"
module sha_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sha_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [255:0]   out_digest
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_ROUND = 3'd2,
		ST_ADD = 3'd3, ST_PAD = 3'd4, ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [31:0] buf_q [16];
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0] rnd_q;
	logic [6:0] ld_q;
	logic last_q;     // the last item of the message has been taken
	logic final_q;    // this compression is the last block
	logic [255:0] dig_q;
	logic dvalid_q;

	logic [31:0] w_cur, w_new, t1, t2, s0, s1, big0, big1, ch, maj;
	logic [5:0] pos;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = dvalid_q;
	assign out_digest = dig_q;
	assign pos = fill_q;

	always_comb begin
		w_cur = w_q[0];
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		big1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha_pkg::round_k(rnd_q) + w_cur;
		big0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
	end

	// buffer writes: message bytes, padding, length; bytes sit big-endian in each word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_item.byte_valid)
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_item.data_byte;
		if (state_q == ST_PAD) begin
			for (int wi = 0; wi < 16; wi++) begin
				for (int bj = 0; bj < 4; bj++) begin
					if (!final_q) begin
						if (4*wi + bj >= 56 && pos < 6'd56)
							buf_q[wi][8*(3-bj) +: 8] <= bits_q[8*(63-4*wi-bj) +: 8];
						else if (4*wi + bj == int'(pos))
							buf_q[wi][8*(3-bj) +: 8] <= 8'h80;
						else if (4*wi + bj > int'(pos))
							buf_q[wi][8*(3-bj) +: 8] <= 8'h00;
					end else begin
						buf_q[wi][8*(3-bj) +: 8] <= (4*wi + bj >= 56) ?
							bits_q[8*(63-4*wi-bj) +: 8] : 8'h00;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			// shift in one word per cycle from the buffer
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= buf_q[ld_q[3:0]];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == ST_LOAD && ld_q == 7'd0)
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			rnd_q <= '0;
			ld_q <= '0;
			last_q <= 1'b0;
			final_q <= 1'b0;
			dvalid_q <= 1'b0;
			dig_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
		end else begin
			if (dvalid_q && out_ready && state_q != ST_OUT) dvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					last_q <= in_item.last_item;
					final_q <= 1'b0;
					if (in_item.byte_valid) begin
						fill_q <= fill_q + 1'b1;
						bits_q <= bits_q + 64'd8;
					end
					if (in_item.byte_valid && fill_q == 6'd63) begin
						ld_q <= '0;
						state_q <= ST_LOAD;
					end else if (in_item.last_item) begin
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					// when pos >= 56 this block gets only the 0x80 marker and zeros; the length follows in a further block
					final_q <= final_q || (pos < 6'd56);
					ld_q <= '0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					ld_q <= ld_q + 1'b1;
					if (ld_q == 7'd15) begin
						rnd_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!last_q) state_q <= ST_IDLE;
					else if (final_q) state_q <= ST_OUT;
					else begin
						// pad block after a full buffer, or length-only spill block
						final_q <= (fill_q != 6'd0);
						state_q <= ST_PAD;
					end
				end
				ST_OUT: if (!dvalid_q || out_ready) begin
					for (int i = 0; i < 8; i++) begin
						dig_q[255-32*i -: 32] <= h_q[i];
						h_q[i] <= sha_pkg::init_h(3'(i));
					end
					dvalid_q <= 1'b1;
					fill_q <= '0;
					bits_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_round_range, clk, arst_n, state_q == ST_LOAD, ld_q < 7'd16)
	`SHA_ASSERT_NXT(a_round_done, clk, arst_n, state_q == ST_ROUND && rnd_q == 6'd63,
		state_q == ST_ADD)
	`SHA_ASSERT_NXT(a_out_reset, clk, arst_n, state_q == ST_OUT && (!dvalid_q || out_ready),
		dvalid_q && fill_q == 6'd0 && bits_q == 64'd0)
endmodule

// File: design/sha256_stream_hash.sv
// The queue registers each accepted item; the engine takes it from there while idle; 64 bytes start a block.
// A block is loaded from the buffer word by word, then runs its 64 rounds, one round per cycle, and the add.
// After a last item the engine pads the block, compresses it and registers the digest for output;
// a length that spills into an extra block adds a further pad step and block compression.
// The engine takes no items while it compresses a block; the queue holds them meanwhile.
// Reset: arst_n clears the queue and engine and loads the initial hash values.
module sha256_stream_hash #(
	parameter int QueueDepth = sha_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	logic q_valid, q_ready;
	sha_pkg::item_t q_item;
	logic [255:0] digest;

	sha_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	sha_engine u_engine (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_digest(digest)
	);

	assign out_ch.payload = digest;
endmodule

// File: dv/sha256_stream_hash_tb.sv
// Testbench for the SHA-256 stream hasher: directed and random messages checked against a local SHA-256
module sha256_stream_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_CYCLES = 400;

	typedef logic [255:0] digest_t;

	logic clk;
	logic arst_n;

	sha_stream_if #(.T(sha_pkg::item_t)) in_ch ();
	sha_stream_if #(.T(digest_t))        out_ch ();

	sha256_stream_hash u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// local hash state
	logic [31:0] hash_h [8];
	logic [7:0]  blk [64];
	int          blk_fill;
	logic [63:0] msg_bits;

	digest_t digest_q[$];
	int      n_items;
	int      n_digests;
	int      n_errors;
	int      burst_left;
	int      stall_left;
	int      cyc;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
				+ (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
		for (int i = 0; i < 8; i++) v[i] = hash_h[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_h[i] += v[i];
	endfunction

	function automatic void hash_reset();
		for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
		blk_fill = 0;
		msg_bits = '0;
	endfunction

	// absorb one item; push the digest when it ends the message
	function automatic void hash_absorb(input sha_pkg::item_t it);
		if (it.byte_valid) begin
			blk[blk_fill] = it.data_byte;
			blk_fill++;
			msg_bits += 64'd8;
			if (blk_fill == 64) begin
				compress();
				blk_fill = 0;
			end
		end
		if (it.last_item) begin
			blk[blk_fill] = 8'h80;
			for (int i = blk_fill + 1; i < 64; i++) blk[i] = 8'h00;
			if (blk_fill >= 56) begin
				compress();
				for (int i = 0; i < 56; i++) blk[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
			compress();
			digest_q.push_back({hash_h[0], hash_h[1], hash_h[2], hash_h[3],
				hash_h[4], hash_h[5], hash_h[6], hash_h[7]});
			hash_reset();
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("%0t timeout, %0d digests outstanding", $realtime, digest_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: stalls in random stretches, with calm windows
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ch.ready <= 1'b1;
				if ((cyc / 3000) % 3 != 2 && $urandom_range(3) == 0)
					stall_left <= $urandom_range(1, 40);
			end
		end
	end

	always @(posedge clk) begin
		digest_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			n_digests++;
			if (digest_q.size() == 0) begin
				$display("%0t unexpected digest %h", $realtime, got);
				n_errors++;
			end else begin
				want = digest_q.pop_front();
				for (int f = 3; f >= 0; f--)
					if (got[64*f +: 64] !== want[64*f +: 64]) begin
						$display("%0t digest bits %0d:%0d expected %h actual %h", $realtime,
							64*f + 63, 64*f, want[64*f +: 64], got[64*f +: 64]);
						n_errors++;
					end
			end
		end
	end

	// one transaction, in bursts separated by random gaps
	task automatic send_item(input logic [7:0] b, input logic bv, input logic last);
		sha_pkg::item_t it;
		int gap;
		it.data_byte = b;
		it.byte_valid = bv;
		it.last_item = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		hash_absorb(it);
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		n_items++;
	endtask

	task automatic send_message(input int len, input bit last_has_byte, input int noise_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (last_has_byte && i == len - 1));
		end
		if (!(last_has_byte && len > 0))
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_empty();
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
	endtask

	task automatic test_ignored_items();
		// items with neither flag must leave the message untouched
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
	endtask

	task automatic test_random();
		int len;
		int start;
		start = n_items;
		while (n_items - start < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					// lengths at the padding and block boundaries
					len = $urandom_range(0, 1) * 64 + 55 + $urandom_range(0, 9);
				end
				3: len = $urandom_range(0, 3);
				default: len = $urandom_range(0, 140);
			endcase
			send_message(len, $urandom_range(1), ($urandom_range(3) == 0) ? 15 : 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		n_items = 0;
		n_digests = 0;
		n_errors = 0;
		burst_left = 0;
		hash_reset();
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty();
		test_byte_extremes();
		test_ignored_items();
		test_random();

		in_ch.valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d input transactions into %0d digests, including empty messages,",
			n_items, n_digests);
		$display("ignored items and lengths around the pad and block boundaries.");
		if (n_errors == 0 && digest_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+design
design/sha_pkg.sv
design/sha_stream_if.sv
design/sha_queue.sv
design/sha_engine.sv
design/sha256_stream_hash.sv
dv/sha256_stream_hash_tb.sv
